// ----- src/pgf_pkg.sv -----
// Shared types and constants for the palette gradient fill block.
// Used by pgf_div, pgf_ctrl, pgf_datapath and palette_gradient_fill.
package pgf_pkg;

  localparam int COLOR_W = 8;
  localparam int IDX_W   = 8;
  localparam int COUNT_W = 9;
  localparam int NUM_CH  = 3;
  localparam int CH_W    = 2;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_GRAD  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic idle;
    logic load;
    logic set_status;
    logic rd_issue;
    logic cap_read;
    logic wr_single;
    logic div_start;
    logic div_next;
    logic fill_wr;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic ok;
    logic div_done;
    logic div_last;
    logic fill_last;
    logic out_busy;
  } stat_t;

endpackage

// ----- src/pgf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pgf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/pgf_div.sv -----
// Bit-serial restoring divider: signed 9-bit numerator by unsigned 8-bit divisor,
// quotient truncated toward zero. Depends on pgf_pkg.
module pgf_div import pgf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COLOR_W:0]   num,
  input  logic [IDX_W-1:0]          den,
  output logic                      done,
  output logic signed [COLOR_W:0]   quot
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  logic [COLOR_W-1:0]  n_r, n_nxt;
  logic [COLOR_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]    d_r, d_nxt;
  logic [COLOR_W:0]    num_abs;
  logic [COLOR_W:0]    rem_sh;
  logic [COLOR_W:0]    mag;

  assign num_abs = num[COLOR_W] ? (COLOR_W+1)'(-num) : num;
  assign rem_sh  = {rem_r, n_r[COLOR_W-1]};
  assign mag     = {1'b0, n_r};
  assign quot    = neg_r ? -$signed(mag) : $signed(mag);
  assign done    = done_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = num[COLOR_W];
      n_nxt    = num_abs[COLOR_W-1:0];
      rem_nxt  = '0;
      d_nxt    = den;
    end else if (busy_r) begin
      // one quotient bit per cycle, MSB first
      if (rem_sh >= {1'b0, d_r}) begin
        rem_nxt = COLOR_W'(rem_sh - {1'b0, d_r});
        n_nxt   = {n_r[COLOR_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[COLOR_W-1:0];
        n_nxt   = {n_r[COLOR_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

endmodule

// ----- src/pgf_ctrl.sv -----
// Sequencing state machine for the palette block: decode, read, divide, fill, finish.
// Depends on pgf_pkg; drives cmd_t to pgf_datapath and reads stat_t back.
module pgf_ctrl import pgf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_READ   = 6'b000100,
    S_DIV    = 6'b001000,
    S_FILL   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        state_nxt      = S_FINISH;
        if (stat.ok) begin
          unique case (stat.op)
            OP_READ: begin
              cmd.rd_issue = 1'b1;
              state_nxt    = S_READ;
            end
            OP_WRITE: begin
              cmd.wr_single = 1'b1;
            end
            OP_GRAD: begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.cap_read = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (stat.div_last) begin
            state_nxt = S_FILL;
          end else begin
            cmd.div_next = 1'b1;
          end
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (stat.fill_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/pgf_datapath.sv -----
// Datapath: operand registers, count register, valid bits, palette RAM, divider,
// fill counter and output register. Depends on pgf_pkg, pgf_ram and pgf_div.
module pgf_datapath import pgf_pkg::*; #(
  parameter int MAX_COLORS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [1:0]         in_op,
  input  logic [IDX_W-1:0]   in_index,
  input  logic [IDX_W-1:0]   in_end_index,
  input  logic [COLOR_W-1:0] in_first_red,
  input  logic [COLOR_W-1:0] in_first_green,
  input  logic [COLOR_W-1:0] in_first_blue,
  input  logic [COLOR_W-1:0] in_second_red,
  input  logic [COLOR_W-1:0] in_second_green,
  input  logic [COLOR_W-1:0] in_second_blue,
  input  logic               cfg_valid,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [COLOR_W-1:0] out_read_red,
  output logic [COLOR_W-1:0] out_read_green,
  output logic [COLOR_W-1:0] out_read_blue,
  output logic [1:0]         out_status
);

  // only indices 0..255 are ever addressable, so storage stops there
  localparam int DEPTH       = (MAX_COLORS < 256) ? MAX_COLORS : 256;
  localparam int AW          = $clog2(DEPTH);
  localparam int CAP         = (MAX_COLORS > 511) ? 511 : MAX_COLORS;
  localparam int ENTRY_W     = NUM_CH * COLOR_W;

  op_t                op_r;
  logic [IDX_W-1:0]   idx_r, end_r;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [COLOR_W-1:0] first_r  [NUM_CH];
  logic [COLOR_W-1:0] second_r [NUM_CH];
  logic [COLOR_W-1:0] acc_r    [NUM_CH];
  logic [COLOR_W-1:0] step_r   [NUM_CH];
  logic [COLOR_W-1:0] rd_r     [NUM_CH];
  logic [CH_W-1:0]    ch_r, ch_sel;
  logic [COUNT_W-1:0] count_r, count_w;
  logic [DEPTH-1:0]   valid_r, valid_nxt;
  logic               rdv_r;
  status_t            status_r, st_code;
  logic               ok;
  logic               idx_in, end_in;
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_rd_r [NUM_CH];
  status_t            out_status_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_q;
  logic               div_start, div_done;
  logic signed [COLOR_W:0] div_num, div_quot;
  logic               cfg_wr;

  // ---------------- decode ----------------
  assign idx_in = {1'b0, idx_r} < count_r;
  assign end_in = {1'b0, end_r} < count_r;

  always_comb begin
    st_code = ST_DONE;
    ok      = 1'b0;
    unique case (op_r)
      OP_READ, OP_WRITE: begin
        if (idx_in) begin
          ok = 1'b1;
        end else begin
          st_code = ST_RANGE;
        end
      end
      OP_GRAD: begin
        priority if (!idx_in || !end_in) begin
          st_code = ST_RANGE;
        end else if (end_r <= idx_r) begin
          st_code = ST_EMPTY;
        end else begin
          ok = 1'b1;
        end
      end
      default: begin
        st_code = ST_DONE;
      end
    endcase
  end

  assign stat.op        = op_r;
  assign stat.ok        = ok;
  assign stat.div_done  = div_done;
  assign stat.div_last  = (ch_r == LAST_CH);
  assign stat.fill_last = (ptr_r == end_r);
  assign stat.out_busy  = out_valid_r && out_stall;

  // ---------------- divider ----------------
  assign div_start = cmd.div_start || cmd.div_next;
  assign ch_sel    = cmd.div_start ? '0 : CH_W'(ch_r + 1'b1);
  assign div_num   = $signed({1'b0, second_r[ch_sel]}) - $signed({1'b0, first_r[ch_sel]});

  pgf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (IDX_W'(end_r - idx_r)),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------- palette RAM ----------------
  assign ram_we    = cmd.wr_single || cmd.fill_wr;
  assign ram_waddr = cmd.fill_wr ? ptr_r[AW-1:0] : idx_r[AW-1:0];
  assign ram_wdata = cmd.fill_wr ? {acc_r[0], acc_r[1], acc_r[2]}
                                 : {first_r[0], first_r[1], first_r[2]};

  pgf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_q)
  );

  // ---------------- count and valid bits ----------------
  assign cfg_wr  = cfg_valid && cmd.idle;
  assign count_w = (32'(cfg_data) > CAP) ? COUNT_W'(CAP) : cfg_data;

  always_comb begin
    valid_nxt = valid_r;
    if (ram_we) begin
      valid_nxt[ram_waddr] = 1'b1;
    end
    if (cfg_wr) begin
      // drop every entry at or above the new count
      for (int k = 0; k < DEPTH; k++) begin
        if (COUNT_W'(k) >= count_w) begin
          valid_nxt[k] = 1'b0;
        end
      end
    end
  end

  assign ptr_nxt = cmd.load ? in_index : IDX_W'(ptr_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= COUNT_W'(DEPTH);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        count_r <= count_w;
      end
      valid_r <= valid_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    if (cmd.load) begin
      op_r        <= op_t'(in_op);
      idx_r       <= in_index;
      end_r       <= in_end_index;
      first_r[0]  <= in_first_red;
      first_r[1]  <= in_first_green;
      first_r[2]  <= in_first_blue;
      second_r[0] <= in_second_red;
      second_r[1] <= in_second_green;
      second_r[2] <= in_second_blue;
      acc_r[0]    <= in_first_red;
      acc_r[1]    <= in_first_green;
      acc_r[2]    <= in_first_blue;
    end else if (cmd.fill_wr) begin
      for (int c = 0; c < NUM_CH; c++) begin
        acc_r[c] <= COLOR_W'(acc_r[c] + step_r[c]);
      end
    end
    if (cmd.load || cmd.fill_wr) begin
      ptr_r <= ptr_nxt;
    end

    if (cmd.div_start) begin
      ch_r <= '0;
    end else if (cmd.div_next) begin
      ch_r <= ch_sel;
    end
    if (div_done) begin
      step_r[ch_r] <= div_quot[COLOR_W-1:0];
    end

    if (cmd.set_status) begin
      status_r <= st_code;
      for (int c = 0; c < NUM_CH; c++) begin
        rd_r[c] <= '0;
      end
    end
    if (cmd.rd_issue) begin
      rdv_r <= valid_r[idx_r[AW-1:0]];
    end
    if (cmd.cap_read) begin
      rd_r[0] <= rdv_r ? ram_q[3*COLOR_W-1:2*COLOR_W] : '0;
      rd_r[1] <= rdv_r ? ram_q[2*COLOR_W-1:COLOR_W]   : '0;
      rd_r[2] <= rdv_r ? ram_q[COLOR_W-1:0]           : '0;
    end

    if (cmd.out_load) begin
      out_rd_r[0]  <= rd_r[0];
      out_rd_r[1]  <= rd_r[1];
      out_rd_r[2]  <= rd_r[2];
      out_status_r <= status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_red   = out_rd_r[0];
  assign out_read_green = out_rd_r[1];
  assign out_read_blue  = out_rd_r[2];
  assign out_status     = out_status_r;

endmodule

// ----- src/palette_gradient_fill.sv -----
// Top level of the palette gradient fill block: controller plus datapath.
// Depends on pgf_pkg, pgf_ctrl and pgf_datapath.
//
// Palette of RGB entries with read, write and linear gradient fill. One transaction
// is in work at a time; the input stalls from acceptance until the result is loaded
// into the output register, and a new transaction may be taken while that result
// waits. A read passes decode, read and finish, taking the registered RAM data in
// the read state; a write, decode and finish. A gradient from index to end_index
// runs three serial divisions in one shared divider, then one RAM write per entry.
// Out-of-range, empty and unused-op transactions go from decode to finish.
// cfg_ready is high while idle; a color_count write clears the entries at or above
// the new count in that same cycle, and a write above MAX_COLORS saturates to it.
module palette_gradient_fill import pgf_pkg::*; #(
  parameter int MAX_COLORS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [IDX_W-1:0]   in_index,
  input  logic [IDX_W-1:0]   in_end_index,
  input  logic [COLOR_W-1:0] in_first_red,
  input  logic [COLOR_W-1:0] in_first_green,
  input  logic [COLOR_W-1:0] in_first_blue,
  input  logic [COLOR_W-1:0] in_second_red,
  input  logic [COLOR_W-1:0] in_second_green,
  input  logic [COLOR_W-1:0] in_second_blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_read_red,
  output logic [COLOR_W-1:0] out_read_green,
  output logic [COLOR_W-1:0] out_read_blue,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign in_stall  = !cmd.idle;
  assign cfg_ready = cmd.idle;

  pgf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  pgf_datapath #(
    .MAX_COLORS (MAX_COLORS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_op),
    .in_index        (in_index),
    .in_end_index    (in_end_index),
    .in_first_red    (in_first_red),
    .in_first_green  (in_first_green),
    .in_first_blue   (in_first_blue),
    .in_second_red   (in_second_red),
    .in_second_green (in_second_green),
    .in_second_blue  (in_second_blue),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_read_red    (out_read_red),
    .out_read_green  (out_read_green),
    .out_read_blue   (out_read_blue),
    .out_status      (out_status)
  );

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result loaded over a pending transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !cmd.idle)
    else $error("controller idle right after accepting a transaction");

  a_no_fill_during_div: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> !cmd.fill_wr)
    else $error("fill write while a division completes");

endmodule
